FILE: hdl/xxh64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_pkg
// Shared constants and types for the streaming 64-bit xxHash block.
// ----------------------------------------------------------------------------
package xxh64_pkg;

	localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_RND_A  = 11'b00000000010,
		ST_RND_B  = 11'b00000000100,
		ST_CONV   = 11'b00000001000,
		ST_MRG_A  = 11'b00000010000,
		ST_MRG_B  = 11'b00000100000,
		ST_BUF_A  = 11'b00001000000,
		ST_BUF_B  = 11'b00010000000,
		ST_TAIL   = 11'b00100000000,
		ST_AVAL   = 11'b01000000000,
		ST_OUT    = 11'b10000000000
	} xxh_state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
		logic [127:0] d;
		d = {x, x} << r;
		return d[127:64];
	endfunction

endpackage : xxh64_pkg
`default_nettype wire

FILE: hdl/xxhash64_stream_hasher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_unit
// Streaming XXH64 over little-endian 64-bit words with one shared multiplier.
// ----------------------------------------------------------------------------
// One 32x32 multiplier is reused under a small sequencer. It forms each 64-bit
// low-half product from three partial products, then a result step.
// The block takes one item at a time.
// - A word that does not complete a stripe is buffered.
// - A word that completes a 32-byte stripe runs the lane rounds: two multiplies
//   per lane.
// A last item then goes through:
// - a step to set up the merge or the short path,
// - the lane merge when a stripe was seen,
// - one fold per buffered word,
// - a fold for a 4-byte tail part and one per single tail byte,
// - the avalanche.
// The hash is then held until the receiver takes it, and input stays stalled
// until then. The seed port is ready whenever no item is in progress.
module xxhash64_stream_hasher_unit #(
	parameter int LEN_BITS = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [63:0]         cfg_data,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [63:0]         data_word,
	input  wire  [3:0]          byte_count,
	input  wire                 last,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [63:0]         hash_value
);
	import xxh64_pkg::*;

	xxh_state_t state_q;
	logic [63:0] seed_q;
	logic [63:0] lane_q [4];
	logic [63:0] buf_q [3];
	logic [1:0]  nbuf_q;
	logic [LEN_BITS-1:0] len_q;
	logic        inmsg_q, seen_q;
	logic [63:0] word_q, h_q, t_q;
	logic [3:0]  cnt_q;       // tail bytes still to fold
	logic [2:0]  bpos_q;      // next tail byte position
	logic        fin_q;
	logic [1:0]  idx_q;       // lane or buffer index
	logic [2:0]  tstep_q;     // tail sub-step / avalanche step
	logic [63:0] mul_a, mul_b, prod;
	logic        mul_need, mul_done;
	logic [1:0]  mph_q;       // multiplier phase
	logic [31:0] mx, my;
	logic [63:0] mp;
	logic [63:0] mlo_q;
	logic [31:0] mhi_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = t_q;
		mul_b = PRIME1;
		case (state_q)
			ST_RND_A, ST_BUF_A: begin
				mul_b = PRIME2;
			end
			ST_MRG_A: begin
				mul_a = lane_q[idx_q];
				mul_b = PRIME2;
			end
			ST_TAIL: begin
				case (tstep_q)
					3'd2: begin
						mul_a = {32'd0, word_q[31:0]};
						mul_b = PRIME1;
					end
					3'd3: begin
						mul_b = PRIME2;
					end
					3'd4: begin
						mul_a = {56'd0, word_q[{bpos_q, 3'b000} +: 8]};
						mul_b = PRIME5;
					end
					default: begin
						mul_b = PRIME1;
					end
				endcase
			end
			ST_AVAL: begin
				mul_b = (tstep_q == 3'd1) ? PRIME2 : PRIME3;
			end
			default: begin
				mul_b = PRIME1;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_RND_A, ST_RND_B, ST_MRG_A, ST_MRG_B, ST_BUF_A, ST_BUF_B, ST_TAIL: begin
				mul_need = 1'b1;
			end
			ST_AVAL: begin
				mul_need = (tstep_q != 3'd0);
			end
			default: begin
				mul_need = 1'b0;
			end
		endcase
	end

	// Low half of a*b = a_lo*b_lo + ((a_lo*b_hi + a_hi*b_lo) << 32).
	always_comb begin
		case (mph_q)
			2'd0: begin
				mx = mul_a[31:0];
				my = mul_b[31:0];
			end
			2'd1: begin
				mx = mul_a[31:0];
				my = mul_b[63:32];
			end
			default: begin
				mx = mul_a[63:32];
				my = mul_b[31:0];
			end
		endcase
	end

	assign mp       = 64'(mx) * 64'(my);
	assign mul_done = (mph_q == 2'd3);
	assign prod     = {mhi_q, mlo_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mph_q <= 2'd0;
		end else if (!mul_need) begin
			mph_q <= 2'd0;
		end else begin
			mph_q <= mph_q + 2'd1;
			case (mph_q)
				2'd0: begin
					mlo_q <= mp;
				end
				2'd1: begin
					mhi_q <= mlo_q[63:32] + mp[31:0];
				end
				2'd2: begin
					mhi_q <= mhi_q + mp[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic [3:0]  cnt_in;
	logic        full_in;
	logic [1:0]  nb_in;
	logic [LEN_BITS-1:0] len_base;
	logic [63:0] len64;
	assign cnt_in   = (byte_count > 4'd8) ? 4'd8 : byte_count;
	assign full_in  = !last || (cnt_in == 4'd8);
	assign nb_in    = inmsg_q ? nbuf_q : 2'd0;
	assign len_base = inmsg_q ? len_q : '0;
	assign len64    = 64'(len_q);

	// Chooses the first tail step from the remaining byte count.
	function automatic logic [2:0] tail_pick(input logic [3:0] c);
		if (c >= 4'd4) return 3'd2;
		else return 3'd4;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign hash_value = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_q  <= '0;
			nbuf_q  <= '0;
			len_q   <= '0;
			inmsg_q <= 1'b0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
			tstep_q <= '0;
			cnt_q   <= '0;
			bpos_q  <= '0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 4; i++) lane_q[i] <= '0;
		end else begin
			if (cfg_valid && cfg_ready) seed_q <= cfg_data;
			if (!mul_need || mul_done) begin
				case (state_q)
					ST_IDLE: begin
						if (in_valid) begin
							if (!inmsg_q) begin
								lane_q[0] <= seed_q + PRIME1 + PRIME2;
								lane_q[1] <= seed_q + PRIME2;
								lane_q[2] <= seed_q;
								lane_q[3] <= seed_q - PRIME1;
								seen_q <= 1'b0;
								inmsg_q <= 1'b1;
							end
							word_q <= data_word;
							fin_q  <= last;
							cnt_q  <= full_in ? 4'd0 : cnt_in;
							bpos_q <= 3'd0;
							len_q  <= len_base + (full_in ? LEN_BITS'(8) : LEN_BITS'(cnt_in));
							if (full_in && nb_in != 2'd3) begin
								buf_q[nb_in] <= data_word;
								nbuf_q <= nb_in + 2'd1;
								state_q <= last ? ST_CONV : ST_IDLE;
							end else if (full_in) begin
								nbuf_q <= nb_in;
								idx_q <= 2'd0;
								t_q <= buf_q[0];
								tstep_q <= 3'd0;
								state_q <= ST_RND_A;
							end else begin
								nbuf_q <= nb_in;
								state_q <= ST_CONV;
							end
						end
					end
					ST_RND_A: begin
						t_q <= rotl64(lane_q[idx_q] + prod, 6'd31);
						state_q <= ST_RND_B;
					end
					ST_RND_B: begin
						lane_q[idx_q] <= prod;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							nbuf_q <= 2'd0;
							seen_q <= 1'b1;
							state_q <= fin_q ? ST_CONV : ST_IDLE;
						end else begin
							t_q <= (idx_q == 2'd2) ? word_q : buf_q[idx_q + 2'd1];
							state_q <= ST_RND_A;
						end
					end
					ST_CONV: begin
						idx_q <= 2'd0;
						if (seen_q) begin
							h_q <= rotl64(lane_q[0], 6'd1) + rotl64(lane_q[1], 6'd7)
								+ rotl64(lane_q[2], 6'd12) + rotl64(lane_q[3], 6'd18);
							state_q <= ST_MRG_A;
						end else begin
							h_q <= seed_q + PRIME5 + len64;
							t_q <= buf_q[0];
							if (nbuf_q != 2'd0) begin
								state_q <= ST_BUF_A;
							end else if (cnt_q != 4'd0) begin
								tstep_q <= tail_pick(cnt_q);
								state_q <= ST_TAIL;
							end else begin
								tstep_q <= 3'd0;
								state_q <= ST_AVAL;
							end
						end
					end
					// Merge: t = rotl(lane*P2,31); then h = (h^(t*P1))*P1+P4.
					ST_MRG_A: begin
						t_q <= rotl64(prod, 6'd31);
						tstep_q <= 3'd0;
						state_q <= ST_MRG_B;
					end
					ST_MRG_B: begin
						if (tstep_q == 3'd0) begin
							t_q <= h_q ^ prod;
							tstep_q <= 3'd1;
						end else if (idx_q == 2'd3) begin
							t_q <= buf_q[0];
							idx_q <= 2'd0;
							h_q <= prod + PRIME4 + len64;
							if (nbuf_q != 2'd0) begin
								state_q <= ST_BUF_A;
							end else if (cnt_q != 4'd0) begin
								tstep_q <= tail_pick(cnt_q);
								state_q <= ST_TAIL;
							end else begin
								tstep_q <= 3'd0;
								state_q <= ST_AVAL;
							end
						end else begin
							h_q <= prod + PRIME4;
							idx_q <= idx_q + 2'd1;
							state_q <= ST_MRG_A;
						end
					end
					// Buffered word: h ^= rotl(w*P2,31)*P1; h = rotl(h,27)*P1+P4.
					ST_BUF_A: begin
						t_q <= rotl64(prod, 6'd31);
						tstep_q <= 3'd0;
						state_q <= ST_BUF_B;
					end
					ST_BUF_B: begin
						if (tstep_q == 3'd0) begin
							t_q <= rotl64(h_q ^ prod, 6'd27);
							tstep_q <= 3'd1;
						end else begin
							h_q <= prod + PRIME4;
							idx_q <= idx_q + 2'd1;
							if (idx_q + 2'd1 == nbuf_q) begin
								if (cnt_q == 4'd0) begin
									tstep_q <= 3'd0;
									state_q <= ST_AVAL;
								end else begin
									tstep_q <= tail_pick(cnt_q);
									state_q <= ST_TAIL;
								end
							end else begin
								t_q <= buf_q[idx_q + 2'd1];
								state_q <= ST_BUF_A;
							end
						end
					end
					// Tail steps: 2/3 = four-byte part, 4/5 = one byte.
					ST_TAIL: begin
						case (tstep_q)
							3'd2: begin
								t_q <= rotl64(h_q ^ prod, 6'd23);
								tstep_q <= 3'd3;
							end
							3'd3: begin
								h_q <= prod + PRIME3;
								cnt_q <= cnt_q - 4'd4;
								bpos_q <= 3'd4;
								if (cnt_q == 4'd4) begin
									tstep_q <= 3'd0;
									state_q <= ST_AVAL;
								end else tstep_q <= 3'd4;
							end
							3'd4: begin
								t_q <= rotl64(h_q ^ prod, 6'd11);
								tstep_q <= 3'd5;
							end
							default: begin
								h_q <= prod;
								cnt_q <= cnt_q - 4'd1;
								bpos_q <= bpos_q + 3'd1;
								if (cnt_q == 4'd1) begin
									tstep_q <= 3'd0;
									state_q <= ST_AVAL;
								end else tstep_q <= 3'd4;
							end
						endcase
					end
					// Avalanche: step 0 shift-xors into t, later steps multiply.
					ST_AVAL: begin
						case (tstep_q)
							3'd0: begin
								t_q <= h_q ^ (h_q >> 33);
								tstep_q <= 3'd1;
							end
							3'd1: begin
								t_q <= prod ^ (prod >> 29);
								tstep_q <= 3'd2;
							end
							default: begin
								h_q <= prod ^ (prod >> 32);
								inmsg_q <= 1'b0;
								nbuf_q <= 2'd0;
								len_q <= '0;
								seen_q <= 1'b0;
								state_q <= ST_OUT;
							end
						endcase
					end
					ST_OUT: begin
						if (!out_stall) state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("result dropped while stalled");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
`endif

endmodule : xxhash64_stream_hasher_unit
`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for xxhash64_stream_hasher_unit
// Streams random and directed messages through the hasher and checks each
// hash against a built-in XXH64 predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import xxh64_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] hash_value;

	xxhash64_stream_hasher_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_word(data_word), .byte_count(byte_count), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .hash_value(hash_value)
	);

	// Predictor state.
	logic [63:0] p_seed;
	logic [63:0] p_lane [4];
	logic [63:0] p_buf [3];
	int unsigned p_nbuf;
	logic [63:0] p_len;
	bit          p_busy;
	bit          p_stripe;

	logic [63:0] hash_queue [$];
	int          error_count;
	int          cycle_count;
	bit          stall_mode;

	function automatic logic [63:0] rl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] round_fn(logic [63:0] acc, logic [63:0] w);
		return rl(acc + w * PRIME2, 31) * PRIME1;
	endfunction

	task automatic take_word(logic [63:0] w);
		if (p_nbuf < 3) begin
			p_buf[p_nbuf] = w;
			p_nbuf++;
		end else begin
			p_lane[0] = round_fn(p_lane[0], p_buf[0]);
			p_lane[1] = round_fn(p_lane[1], p_buf[1]);
			p_lane[2] = round_fn(p_lane[2], p_buf[2]);
			p_lane[3] = round_fn(p_lane[3], w);
			p_nbuf = 0;
			p_stripe = 1;
		end
		p_len += 64'd8;
	endtask

	// Advances the predictor by one item; returns 1 with the hash on a last item.
	task automatic hash_predict(logic [63:0] w, logic [3:0] cnt_in, bit fin,
			output bit done, output logic [63:0] h);
		int unsigned cnt;
		int i;
		cnt = (cnt_in > 8) ? 8 : cnt_in;
		done = 0;
		h = '0;
		if (!p_busy) begin
			p_lane[0] = p_seed + PRIME1 + PRIME2;
			p_lane[1] = p_seed + PRIME2;
			p_lane[2] = p_seed;
			p_lane[3] = p_seed - PRIME1;
			p_nbuf = 0;
			p_len = '0;
			p_stripe = 0;
			p_busy = 1;
		end
		if (!fin) begin
			take_word(w);
			return;
		end
		if (cnt == 8) begin
			take_word(w);
			cnt = 0;
		end else begin
			p_len += 64'(cnt);
		end
		if (p_stripe) begin
			h = rl(p_lane[0], 1) + rl(p_lane[1], 7) + rl(p_lane[2], 12) + rl(p_lane[3], 18);
			for (i = 0; i < 4; i++) begin
				h ^= round_fn('0, p_lane[i]);
				h = h * PRIME1 + PRIME4;
			end
		end else begin
			h = p_seed + PRIME5;
		end
		h += p_len;
		for (i = 0; i < int'(p_nbuf); i++) begin
			h ^= round_fn('0, p_buf[i]);
			h = rl(h, 27) * PRIME1 + PRIME4;
		end
		i = 0;
		if (cnt >= 4) begin
			h ^= {32'd0, w[31:0]} * PRIME1;
			h = rl(h, 23) * PRIME2 + PRIME3;
			i = 4;
		end
		for (; i < int'(cnt); i++) begin
			h ^= {56'd0, w[8*i +: 8]} * PRIME5;
			h = rl(h, 11) * PRIME1;
		end
		h ^= h >> 33;
		h *= PRIME2;
		h ^= h >> 29;
		h *= PRIME3;
		h ^= h >> 32;
		done = 1;
		p_busy = 0;
		p_nbuf = 0;
		p_len = '0;
		p_stripe = 0;
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout");
				$display("FAIL xxhash64_stream_hasher_unit");
				$finish;
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hash_queue.size() == 0) begin
				report_mismatch("unexpected hash", hash_value, '0);
			end else begin
				logic [63:0] want;
				want = hash_queue.pop_front();
				if (hash_value !== want)
					report_mismatch("hash_value", hash_value, want);
			end
		end
	end

	// Receiver stall pattern: alternates between free flow and random stalls.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				stall_mode = ~stall_mode;
			out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
		end
	end

	typedef struct {
		logic [63:0] word;
		logic [3:0]  cnt;
		bit          fin;
		bit          known;
		logic [63:0] hash;
	} stim_row_t;

	stim_row_t directed_rows [$];
	int burst_left;

	task automatic send_item(logic [63:0] w, logic [3:0] cnt, bit fin, bit known,
			logic [63:0] known_hash);
		bit done;
		logic [63:0] h;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1;
		data_word <= w;
		byte_count <= cnt;
		last <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hash_predict(w, cnt, fin, done, h);
		if (done) begin
			if (known && h !== known_hash)
				report_mismatch("directed row predictor", h, known_hash);
			hash_queue.push_back(h);
		end
		@(negedge clk);
	endtask

	task automatic write_seed(logic [63:0] v);
		in_valid <= 0;
		while (hash_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		p_seed = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic random_message(int maxwords);
		int n;
		int k;
		logic [3:0] c;
		n = $urandom_range(0, maxwords);
		for (k = 0; k < n; k++) begin
			// Occasional short or oversized counts on non-last items.
			c = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
			send_item(rand64(), c, 0, 0, '0);
		end
		c = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		send_item(rand64(), c, 1, 0, '0);
	endtask

	initial begin
		int r;
		int m;
		logic [63:0] seeds [5];
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		in_valid = 0;
		data_word = '0;
		byte_count = '0;
		last = 0;
		burst_left = 0;
		p_seed = '0;
		p_busy = 0;
		p_nbuf = 0;
		p_len = '0;
		p_stripe = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Empty message with seed zero has a well-known hash.
		directed_rows.push_back('{64'h0, 4'd0, 1, 1, 64'hEF46DB3751D8E999});
		directed_rows.push_back('{64'hFFFFFFFFFFFFFFFF, 4'd8, 1, 0, '0});
		directed_rows.push_back('{64'h0000000000000061, 4'd1, 1, 0, '0});
		directed_rows.push_back('{64'hFFFFFFFFFFFFFFFF, 4'd4, 1, 0, '0});
		directed_rows.push_back('{64'hFFFFFFFFFFFFFFFF, 4'd7, 1, 0, '0});
		directed_rows.push_back('{64'hAAAAAAAAAAAAAAAA, 4'd15, 1, 0, '0});
		for (r = 0; r < 4; r++)
			directed_rows.push_back('{64'h0123456789ABCDEF ^ 64'(r), 4'd8, 0, 0, '0});
		directed_rows.push_back('{64'h5555555555555555, 4'd3, 1, 0, '0});
		for (r = 0; r < 3; r++)
			directed_rows.push_back('{64'hFFFFFFFF00000000, 4'd2, 0, 0, '0});
		directed_rows.push_back('{64'h0, 4'd0, 1, 0, '0});
		for (r = 0; r < 7; r++)
			directed_rows.push_back('{64'hFEDCBA9876543210 + 64'(r), 4'd12, 0, 0, '0});
		directed_rows.push_back('{64'h00000000000000FF, 4'd5, 1, 0, '0});
		foreach (directed_rows[i])
			send_item(directed_rows[i].word, directed_rows[i].cnt, directed_rows[i].fin,
				directed_rows[i].known, directed_rows[i].hash);

		seeds[0] = 64'hFFFFFFFFFFFFFFFF;
		seeds[1] = 64'h0000000000000001;
		seeds[2] = rand64();
		seeds[3] = 64'h8000000000000000;
		seeds[4] = '0;
		for (r = 0; r < 5; r++) begin
			write_seed(seeds[r]);
			for (m = 0; m < 46; m++)
				random_message(($urandom_range(0, 7) == 0) ? 24 : 6);
		end

		in_valid <= 0;
		while (hash_queue.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (error_count == 0)
			$display("PASS xxhash64_stream_hasher_unit");
		else
			$display("FAIL xxhash64_stream_hasher_unit");
		$finish;
	end
endmodule

FILE: sim.f
hdl/xxh64_pkg.sv
hdl/xxhash64_stream_hasher_unit.sv
tb/sv/testbench.sv
